// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both sample on clock and hold off
// while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/rsms_pkg.sv
// ----------------------------------------------------------------------------
// rsms_pkg - run/stop sequencer shared definitions
// Mode codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package rsms_pkg;

   localparam int TimeWidth  = 32;
   localparam int DelayWidth = 16;
   localparam int SpeedWidth = 16;
   localparam int CountWidth = 4;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 16;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_READY    = 3'd1,
      MODE_RUNNING  = 3'd2,
      MODE_STOPPING = 3'd3,
      MODE_FINISHED = 3'd4,
      MODE_FAULT    = 3'd5
   } mode_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_READY_DELAY = 3'd0,
      CSR_SLOW_TIME   = 3'd1,
      CSR_HOLD_TIME   = 3'd2,
      CSR_THRESHOLD   = 3'd3,
      CSR_RUN_SPEED   = 3'd4,
      CSR_SLOW_SPEED  = 3'd5
   } csr_index_type;

   localparam logic [DelayWidth-1:0] ReadyDelayReset = 16'd1000;
   localparam logic [DelayWidth-1:0] SlowTimeReset   = 16'd700;
   localparam logic [DelayWidth-1:0] HoldTimeReset   = 16'd400;
   localparam logic [CountWidth-1:0] ThresholdReset  = 4'd2;
   // -1.66 and -0.8 in Q4.12
   localparam logic signed [SpeedWidth-1:0] RunSpeedReset  = -16'sd6799;
   localparam logic signed [SpeedWidth-1:0] SlowSpeedReset = -16'sd3277;

endpackage

// File: rtl/run_stop_mission_sequencer_top.sv
// ----------------------------------------------------------------------------
// run_stop_mission_sequencer_top - vehicle run/stop mission sequencer
// One request per periodic task call; one response with mode, flags and the
// commanded Q4.12 speed per request.
// ----------------------------------------------------------------------------
//
//   channel | ports                       | direction | handshake
//   --------+-----------------------------+-----------+--------------------
//   request | req_now_ms .. req_clear_stop | in        | req_valid/req_ready
//   response| rsp_mode .. rsp_target_speed | out       | rsp_valid/rsp_ready
//   csr     | csr_index, csr_wdata         | in        | csr_we, no wait
//
// The response follows its request through the request register, which holds
// it until the state update writes the state registers, which double as the
// response register. A request can be taken every cycle while responses are
// taken; the single state update per cycle sets that rate.
// Reset is synchronous and returns state and CSRs to their defaults.
// A stalled response holds both stages; the request register still takes
// a request when it is empty.
module run_stop_mission_sequencer_top (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [rsms_pkg::TimeWidth-1:0]         req_now_ms,
   input  logic                                   req_sensor_valid,
   input  logic                                   req_start_pulse,
   input  logic                                   req_fault_pulse,
   input  logic                                   req_reset_pulse,
   input  logic                                   req_clear_stop,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [2:0]                             rsp_mode,
   output logic                                   rsp_started,
   output logic                                   rsp_stop_requested,
   output logic signed [rsms_pkg::SpeedWidth-1:0] rsp_target_speed,
   // configuration
   input  logic                                   csr_we,
   input  logic [rsms_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [rsms_pkg::CsrDataWidth-1:0]      csr_wdata
);
   import rsms_pkg::*;

   // ---------------------------------------------------------------- CSRs
   logic [DelayWidth-1:0]        ready_delay_ff;
   logic [DelayWidth-1:0]        slow_time_ff;
   logic [DelayWidth-1:0]        hold_time_ff;
   logic [CountWidth-1:0]        threshold_ff;
   logic signed [SpeedWidth-1:0] run_speed_ff;
   logic signed [SpeedWidth-1:0] slow_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_delay_ff <= ReadyDelayReset;
         slow_time_ff   <= SlowTimeReset;
         hold_time_ff   <= HoldTimeReset;
         threshold_ff   <= ThresholdReset;
         run_speed_ff   <= RunSpeedReset;
         slow_speed_ff  <= SlowSpeedReset;
      end else if (csr_we) begin
         case (csr_index)
            CSR_READY_DELAY: ready_delay_ff <= csr_wdata;
            CSR_SLOW_TIME:   slow_time_ff   <= csr_wdata;
            CSR_HOLD_TIME:   hold_time_ff   <= csr_wdata;
            CSR_THRESHOLD:   threshold_ff   <= csr_wdata[CountWidth-1:0];
            CSR_RUN_SPEED:   run_speed_ff   <= csr_wdata;
            CSR_SLOW_SPEED:  slow_speed_ff  <= csr_wdata;
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   // ---------------------------------------------------- request register
   logic                 in_valid_ff;
   logic [TimeWidth-1:0] in_now_ff;
   logic                 in_sensor_ff;
   logic                 in_start_ff;
   logic                 in_fault_ff;
   logic                 in_rst_ff;
   logic                 in_clr_ff;
   logic                 rsp_valid_ff;
   logic                 advance;

   // Advance the held request into the state when the response slot frees.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_now_ff    <= req_now_ms;
         in_sensor_ff <= req_sensor_valid;
         in_start_ff  <= req_start_pulse;
         in_fault_ff  <= req_fault_pulse;
         in_rst_ff    <= req_reset_pulse;
         in_clr_ff    <= req_clear_stop;
      end
   end

   // -------------------------------------------------------- state update
   mode_type                     mode_ff, mode_in;
   logic [TimeWidth-1:0]         entry_ff, entry_in;
   logic                         started_ff, started_in;
   logic                         stop_ff, stop_in;
   logic [CountWidth-1:0]        count_ff, count_in;
   logic                         armed_ff, armed_in;
   logic signed [SpeedWidth-1:0] speed_ff, speed_in;

   // State after the reset and clear-stop pulses are applied.
   mode_type                     mode_pre;
   logic [TimeWidth-1:0]         entry_pre;
   logic                         started_pre;
   logic                         stop_pre;
   logic [CountWidth-1:0]        count_pre;
   logic                         armed_pre;
   logic signed [SpeedWidth-1:0] speed_pre;

   logic [TimeWidth-1:0]         elapsed;
   logic [DelayWidth:0]          slow_hold_sum;
   logic                         start_taken;
   logic [CountWidth-1:0]        count_hit;

   always_comb begin
      mode_pre    = in_rst_ff ? MODE_IDLE : mode_ff;
      entry_pre   = in_rst_ff ? in_now_ff : entry_ff;
      started_pre = in_rst_ff ? 1'b0 : started_ff;
      stop_pre    = (in_rst_ff || in_clr_ff) ? 1'b0 : stop_ff;
      count_pre   = in_rst_ff ? '0 : count_ff;
      armed_pre   = in_rst_ff ? 1'b0 : armed_ff;
      speed_pre   = in_rst_ff ? '0 : speed_ff;

      start_taken = in_start_ff &&
                    (mode_pre == MODE_IDLE || mode_pre == MODE_FINISHED);
      elapsed       = in_now_ff - entry_pre;
      slow_hold_sum = {1'b0, slow_time_ff} + {1'b0, hold_time_ff};

      // Saturating count of consecutive valid detections; zero on a miss.
      if (!in_sensor_ff) begin
         count_hit = '0;
      end else if (count_pre < threshold_ff) begin
         count_hit = count_pre + 1'b1;
      end else begin
         count_hit = count_pre;
      end

      mode_in    = mode_pre;
      entry_in   = entry_pre;
      started_in = started_pre;
      stop_in    = stop_pre;
      count_in   = count_pre;
      armed_in   = armed_pre;
      speed_in   = speed_pre;

      if (in_fault_ff) begin
         // Fault wins over everything, including a start in the same call.
         mode_in    = MODE_FAULT;
         entry_in   = in_now_ff;
         started_in = 1'b0;
         speed_in   = '0;
      end else begin
         case (mode_pre)
            MODE_IDLE, MODE_FINISHED: begin
               if (start_taken) begin
                  mode_in    = MODE_READY;
                  entry_in   = in_now_ff;
                  stop_in    = 1'b0;
                  started_in = 1'b0;
                  count_in   = '0;
                  armed_in   = 1'b0;
                  speed_in   = '0;
               end else if (mode_pre == MODE_FINISHED) begin
                  speed_in = '0;
               end
            end
            MODE_READY: begin
               if (elapsed >= {{(TimeWidth-DelayWidth){1'b0}}, ready_delay_ff}) begin
                  mode_in    = MODE_RUNNING;
                  entry_in   = in_now_ff;
                  count_in   = '0;
                  armed_in   = 1'b0;
                  started_in = 1'b1;
                  speed_in   = run_speed_ff;
               end
            end
            MODE_RUNNING: begin
               if (!armed_pre) begin
                  // Arm only after the line has been lost once.
                  armed_in = !in_sensor_ff;
               end else begin
                  count_in = count_hit;
                  if (count_hit >= threshold_ff) begin
                     mode_in  = MODE_STOPPING;
                     entry_in = in_now_ff;
                     stop_in  = 1'b1;
                  end
               end
            end
            MODE_STOPPING: begin
               if (elapsed < {{(TimeWidth-DelayWidth){1'b0}}, slow_time_ff}) begin
                  speed_in = slow_speed_ff;
               end else if (elapsed <
                            {{(TimeWidth-DelayWidth-1){1'b0}}, slow_hold_sum}) begin
                  speed_in = '0;
               end else begin
                  mode_in    = MODE_FINISHED;
                  entry_in   = in_now_ff;
                  started_in = 1'b0;
                  speed_in   = '0;
               end
            end
            MODE_FAULT: begin
               speed_in = '0;
            end
            default: ;
         endcase
      end
   end

   // State registers are also the response register: they only move when
   // a request advances, so a stalled response holds.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         entry_ff     <= '0;
         started_ff   <= 1'b0;
         stop_ff      <= 1'b0;
         count_ff     <= '0;
         armed_ff     <= 1'b0;
         speed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            mode_ff    <= mode_in;
            entry_ff   <= entry_in;
            started_ff <= started_in;
            stop_ff    <= stop_in;
            count_ff   <= count_in;
            armed_ff   <= armed_in;
            speed_ff   <= speed_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mode           = mode_ff;
   assign rsp_started        = started_ff;
   assign rsp_stop_requested = stop_ff;
   assign rsp_target_speed   = speed_ff;

   // ----------------------------------------------------------- assertions
   `include "assert_macros.svh"

   `ASSERT_NOW(a_fault_zero_speed, mode_ff == MODE_FAULT, speed_ff == '0 && !started_ff, "fault")
   `ASSERT_NOW(a_started_mode, started_ff, mode_ff == MODE_RUNNING || mode_ff == MODE_STOPPING, "started")
   `ASSERT_NEXT(a_held_request_kept, in_valid_ff && !advance, in_valid_ff && $stable(in_now_ff), "held")
   `ASSERT_NEXT(a_advance_gives_rsp, advance, rsp_valid_ff, "no response after advance")

endmodule
